### rtl/sobol_sequence_generator_assert.svh
// ----------------------------------------------------------------------------
// sobol sequence generator assertion macros
// concurrent assertion forms used by the ssg_datapath module
// ----------------------------------------------------------------------------
`ifndef SOBOL_SEQUENCE_GENERATOR_ASSERT_SVH
`define SOBOL_SEQUENCE_GENERATOR_ASSERT_SVH

// same-cycle implication under reset
`define SSG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssg assertion failed");

// next-cycle implication under reset
`define SSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssg assertion failed");

`endif

### rtl/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg
// types and codes shared by the sobol sequence generator modules
// ----------------------------------------------------------------------------
package ssg_pkg;

    localparam logic [2:0] KIND_POLY    = 3'd0;
    localparam logic [2:0] KIND_SEED    = 3'd1;
    localparam logic [2:0] KIND_BUILD   = 3'd2;
    localparam logic [2:0] KIND_NEXT    = 3'd3;
    localparam logic [2:0] KIND_SKIP    = 3'd4;
    localparam logic [2:0] KIND_RESTART = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  dimension_index;
        logic [4:0]  seed_index;
        logic [31:0] seed_value;
        logic [5:0]  degree;
        logic [30:0] coefficient_bits;
    } item_t;

    typedef struct packed {
        logic [31:0] coordinate;
        logic [3:0]  dimension;
        logic        last;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic       take;
        logic       poly_wr;
        logic       seed_wr;
        logic       cnt_clear;
        logic       adv_start;
        logic       adv_rd;
        logic       adv_upd;
        logic       emit;
        logic       bld_start;
        logic       bld_rd;
        logic       bld_acc;
        logic       bld_wr;
        logic       resp_load;
        logic [1:0] resp_status;
    } cmd_t;

    typedef struct packed {
        logic       item_valid;
        logic [2:0] kind;
        logic       bad;
        logic       exhausted;
        logic       bld_skip;
        logic       out_free;
        logic       emit_ok;
        logic       d_last;
        logic       k_one;
        logic       i_last;
    } sts_t;

endpackage

### rtl/ssg_datapath.sv
// ----------------------------------------------------------------------------
// ssg_datapath
// item capture, direction memory, coordinates, counter and result register
// ----------------------------------------------------------------------------
module ssg_datapath #(
    parameter int MAX_DIMS  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ssg_pkg::item_t   item,
    input  logic             item_valid,
    input  logic             cfg_write,
    input  logic [4:0]       cfg_wdata,
    input  ssg_pkg::cmd_t    cmd,
    output ssg_pkg::sts_t    sts,
    output logic             result_valid,
    input  logic             result_ready,
    output ssg_pkg::result_t result
);

    localparam int ACT   = (MAX_DIMS < 16) ? MAX_DIMS : 16;
    localparam int DW    = (ACT > 1) ? $clog2(ACT) : 1;
    localparam int CW    = $clog2(WORD_BITS);
    localparam int AW    = DW + CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [4:0] TOP_BIT = 5'(WORD_BITS - 1);

    // captured item
    logic [2:0]  kind_reg;
    logic [3:0]  dim_reg;
    logic [4:0]  sidx_reg;
    logic [31:0] sval_reg;
    logic [5:0]  deg_reg;
    logic [30:0] coef_reg;

    logic [WORD_BITS-1:0] counter_reg;
    logic [31:0] coord_reg [ACT];
    logic [4:0]  dims_reg;
    logic [4:0]  n_reg;
    logic [CW-1:0] c_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] k_reg;
    logic [4:0]  s_reg;
    logic [30:0] a_reg;
    logic [31:0] acc_reg;

    logic [5:0]  poly_deg_mem [ACT];
    logic [30:0] poly_coef_mem [ACT];
    logic [31:0] dir_mem [DEPTH];
    logic [31:0] mem_q;

    logic            out_valid_reg;
    ssg_pkg::result_t out_reg;

    logic [WORD_BITS-1:0] zero_mask;
    logic [CW-1:0] c_calc;
    logic [DW-1:0] dsel;
    logic [5:0]    deg_sel;
    logic [31:0]   dir_val;
    logic [31:0]   coord_new;
    logic [4:0]    n_clamp;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          out_free;

    assign dsel    = dim_reg[DW-1:0];
    assign deg_sel = poly_deg_mem[dsel];
    assign out_free = !out_valid_reg || result_ready;

    // rightmost zero of the counter as a one-hot mask, then encoded
    assign zero_mask = ~counter_reg & (counter_reg + 1'b1);
    always_comb
    begin
        c_calc = '0;
        for (int b = 0; b < CW; b++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if (((j >> b) & 1) == 1)
                    c_calc[b] = c_calc[b] | zero_mask[j];
            end
        end
    end

    // dimension zero directions are fixed
    assign dir_val   = (d_reg == '0) ? (32'h1 << (TOP_BIT - 5'(c_reg))) : mem_q;
    assign coord_new = coord_reg[d_reg] ^ dir_val;

    always_comb
    begin
        if (dims_reg == 5'd0)
            n_clamp = 5'd1;
        else if (32'(dims_reg) > ACT)
            n_clamp = 5'(ACT);
        else
            n_clamp = dims_reg;
    end

    always_comb
    begin
        wr_en   = cmd.seed_wr || cmd.bld_wr;
        wr_addr = cmd.seed_wr ? {dsel, sidx_reg[CW-1:0]} : {dsel, i_reg};
        wr_data = cmd.seed_wr ? (sval_reg << (TOP_BIT - sidx_reg)) : acc_reg;
        rd_en   = cmd.adv_rd || cmd.bld_rd;
        rd_addr = cmd.adv_rd ? {d_reg, c_reg} : {dsel, i_reg - k_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            dir_mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_q <= dir_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && item_valid)
        begin
            kind_reg <= item.kind;
            dim_reg  <= item.dimension_index;
            sidx_reg <= item.seed_index;
            sval_reg <= item.seed_value;
            deg_reg  <= item.degree;
            coef_reg <= item.coefficient_bits;
        end
        if (cmd.poly_wr)
        begin
            poly_deg_mem[dsel]  <= deg_reg;
            poly_coef_mem[dsel] <= coef_reg;
        end
        if (cmd.bld_start)
        begin
            s_reg <= deg_sel[4:0];
            a_reg <= poly_coef_mem[dsel];
            i_reg <= CW'(deg_sel);
            k_reg <= CW'(deg_sel);
        end
        if (cmd.bld_acc)
        begin
            if (k_reg == CW'(s_reg))
                acc_reg <= mem_q ^ (mem_q >> s_reg);
            else if (a_reg[s_reg - 5'd1 - 5'(k_reg)])
                acc_reg <= acc_reg ^ mem_q;
            k_reg <= k_reg - 1'b1;
        end
        if (cmd.bld_wr)
        begin
            i_reg <= i_reg + 1'b1;
            k_reg <= CW'(s_reg);
        end
        if (cmd.adv_start)
        begin
            c_reg <= c_calc;
            d_reg <= '0;
            n_reg <= n_clamp;
        end
        if (cmd.adv_upd)
            d_reg <= d_reg + 1'b1;
        if (cmd.emit)
        begin
            out_reg.coordinate <= coord_new;
            out_reg.dimension  <= 4'(d_reg);
            out_reg.last       <= (5'(d_reg) == n_reg - 5'd1);
            out_reg.status     <= ssg_pkg::ST_OK;
        end
        else if (cmd.resp_load)
        begin
            out_reg.coordinate <= '0;
            out_reg.dimension  <= (kind_reg <= ssg_pkg::KIND_BUILD) ? dim_reg : 4'd0;
            out_reg.last       <= 1'b1;
            out_reg.status     <= cmd.resp_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            dims_reg      <= 5'd1;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < ACT; d++)
                coord_reg[d] <= '0;
        end
        else
        begin
            if (cfg_write)
                dims_reg <= cfg_wdata;
            if (cmd.cnt_clear)
            begin
                counter_reg <= '0;
                for (int d = 0; d < ACT; d++)
                    coord_reg[d] <= '0;
            end
            else
            begin
                if (cmd.adv_start)
                    counter_reg <= counter_reg + 1'b1;
                if (cmd.adv_upd)
                    coord_reg[d_reg] <= coord_new;
            end
            if (cmd.emit || cmd.resp_load)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.item_valid = item_valid;
        sts.kind       = kind_reg;
        sts.bad        = (dim_reg == 4'd0) || (32'(dim_reg) >= MAX_DIMS)
                         || ((kind_reg == ssg_pkg::KIND_POLY) && (deg_reg == 6'd0))
                         || ((kind_reg == ssg_pkg::KIND_SEED)
                             && (32'(sidx_reg) >= WORD_BITS));
        sts.exhausted  = &counter_reg;
        sts.bld_skip   = (deg_sel == 6'd0) || (deg_sel >= 6'(WORD_BITS));
        sts.out_free   = out_free;
        sts.emit_ok    = 5'(d_reg) < n_reg;
        sts.d_last     = d_reg == DW'(ACT - 1);
        sts.k_one      = k_reg == CW'(1);
        sts.i_last     = i_reg == CW'(WORD_BITS - 1);
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`include "sobol_sequence_generator_assert.svh"

    `SSG_ASSERT_NOW(a_adv_not_exhausted, clk, rst_n, cmd.adv_start, !(&counter_reg))
    `SSG_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.emit || cmd.resp_load, out_free)
    `SSG_ASSERT_NEXT(a_restart_clears, clk, rst_n, cmd.cnt_clear, counter_reg == '0)

endmodule

### rtl/ssg_controller.sv
// ----------------------------------------------------------------------------
// ssg_controller
// sequencer for setup, build, advance and restart items
// ----------------------------------------------------------------------------
module ssg_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  ssg_pkg::sts_t sts,
    output ssg_pkg::cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_RESP     = 8'b0000_0100,
        S_ADV_RD   = 8'b0000_1000,
        S_ADV_UPD  = 8'b0001_0000,
        S_BLD_RD   = 8'b0010_0000,
        S_BLD_ACC  = 8'b0100_0000,
        S_BLD_WR   = 8'b1000_0000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    logic       is_next;

    assign is_next = sts.kind == ssg_pkg::KIND_NEXT;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.resp_status = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (sts.item_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                status_next = ssg_pkg::ST_OK;
                state_next  = S_RESP;
                case (sts.kind)
                    ssg_pkg::KIND_POLY:
                        if (sts.bad)
                            status_next = ssg_pkg::ST_REJECTED;
                        else
                            cmd.poly_wr = 1'b1;
                    ssg_pkg::KIND_SEED:
                        if (sts.bad)
                            status_next = ssg_pkg::ST_REJECTED;
                        else
                            cmd.seed_wr = 1'b1;
                    ssg_pkg::KIND_BUILD:
                        if (sts.bad)
                            status_next = ssg_pkg::ST_REJECTED;
                        else if (!sts.bld_skip)
                        begin
                            cmd.bld_start = 1'b1;
                            state_next    = S_BLD_RD;
                        end
                    ssg_pkg::KIND_NEXT, ssg_pkg::KIND_SKIP:
                        if (sts.exhausted)
                            status_next = ssg_pkg::ST_EXHAUSTED;
                        else
                        begin
                            cmd.adv_start = 1'b1;
                            state_next    = S_ADV_RD;
                        end
                    ssg_pkg::KIND_RESTART:
                        cmd.cnt_clear = 1'b1;
                    default:
                        status_next = ssg_pkg::ST_REJECTED;
                endcase
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ADV_RD:
            begin
                cmd.adv_rd = 1'b1;
                state_next = S_ADV_UPD;
            end
            S_ADV_UPD:
            begin
                if (!(is_next && sts.emit_ok && !sts.out_free))
                begin
                    cmd.adv_upd = 1'b1;
                    cmd.emit    = is_next && sts.emit_ok;
                    if (!sts.d_last)
                        state_next = S_ADV_RD;
                    else if (is_next)
                        state_next = S_IDLE;
                    else
                    begin
                        status_next = ssg_pkg::ST_OK;
                        state_next  = S_RESP;
                    end
                end
            end
            S_BLD_RD:
            begin
                cmd.bld_rd = 1'b1;
                state_next = S_BLD_ACC;
            end
            S_BLD_ACC:
            begin
                cmd.bld_acc = 1'b1;
                state_next  = sts.k_one ? S_BLD_WR : S_BLD_RD;
            end
            S_BLD_WR:
            begin
                cmd.bld_wr = 1'b1;
                if (sts.i_last)
                begin
                    status_next = ssg_pkg::ST_OK;
                    state_next  = S_RESP;
                end
                else
                    state_next = S_BLD_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ssg_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

### rtl/sobol_sequence_generator.sv
// a setup, restart or rejected item presents its one result from the response state after dispatch
// next point: each coordinate follows a direction read and waits while the result register is full
// every advance steps all stored dimensions, at most 16, through a read and an update state each
// build: s read and accumulate steps, then a write, for each of the WORD_BITS - s recomputed entries, s = degree
// throughput is one item in flight; the memory read port and the sequencer set the pace
// reset clears counter, coordinates, controller and result valid; dimension 0 is fixed
// ----------------------------------------------------------------------------
// sobol_sequence_generator
// gray-code sobol point generator, 0.32 fixed-point coordinates
// ----------------------------------------------------------------------------
module sobol_sequence_generator #(
    parameter int MAX_DIMS  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    // item channel, one transfer per command
    input  logic             item_valid,
    output logic             item_ready,
    input  ssg_pkg::item_t   item,
    // result channel
    output logic             result_valid,
    input  logic             result_ready,
    output ssg_pkg::result_t result,
    // dimensions_in_use register
    input  logic             cfg_write,
    input  logic [4:0]       cfg_wdata
);

    ssg_pkg::cmd_t cmd;
    ssg_pkg::sts_t sts;

    // item is taken only while the sequencer waits for work
    assign item_ready = cmd.take;

    // sequencer: decodes each item and steps the datapath
    ssg_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // datapath: direction memory, coordinates, counter and result register
    ssg_datapath #(
        .MAX_DIMS  (MAX_DIMS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .cfg_write    (cfg_write),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sobol sequence generator: loads every dimension but the fixed one,
// then runs directed and random commands under several dimension counts while
// an in-bench predictor checks each coordinate, status and last flag
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DIMS       = 16;
    localparam int WBITS      = 32;
    localparam int RUN_LIMIT  = 1000000;
    localparam int SETTLE     = 40;
    localparam logic [2:0] KIND_BAD6 = 3'd6;
    localparam logic [2:0] KIND_BAD7 = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    ssg_pkg::item_t   item;
    logic        result_valid;
    logic        result_ready;
    ssg_pkg::result_t result;
    logic        cfg_write;
    logic [4:0]  cfg_wdata;

    // predictor state, kept in step with the items as they are queued
    logic [31:0] dir_tab [DIMS][WBITS];
    logic [5:0]  poly_deg [DIMS];
    logic [30:0] poly_coef [DIMS];
    logic [31:0] coord [DIMS];
    logic [31:0] point_cnt;
    logic [4:0]  dims_reg;

    ssg_pkg::item_t   pending_items[$];
    ssg_pkg::result_t coords_due[$];

    int          errors;
    int          items_sent;
    int          results_seen;
    int          points_seen;
    int          cyc;
    int          tx_gap;
    int          rx_gap;
    int          hold_left;
    bit          hold_done;
    bit          quiet;

    sobol_sequence_generator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap lengths: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        $display("[%0d] %s mismatch: expected %h got %h", cyc, what, want, got);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    // recompute the direction numbers of one dimension from its polynomial
    function automatic void rebuild_directions(int d);
        int s;
        logic [31:0] x;
        s = poly_deg[d];
        if (s == 0 || s >= WBITS)
            return;
        for (int i = s; i < WBITS; i++)
        begin
            x = dir_tab[d][i - s] ^ (dir_tab[d][i - s] >> s);
            for (int k = 1; k < s; k++)
                if (poly_coef[d][s - 1 - k])
                    x ^= dir_tab[d][i - k];
            dir_tab[d][i] = x;
        end
    endfunction

    // gray-code step: xor the direction of the rightmost zero counter bit
    function automatic bit step_point();
        int c;
        if (point_cnt == '1)
            return 1'b0;
        c = 0;
        while (point_cnt[c] && c < WBITS - 1)
            c++;
        for (int d = 0; d < DIMS; d++)
            coord[d] ^= dir_tab[d][c];
        point_cnt++;
        return 1'b1;
    endfunction

    function automatic void predict_results(ssg_pkg::item_t it);
        ssg_pkg::result_t r;
        int n;
        r = '0;
        r.last = 1'b1;
        r.status = ssg_pkg::ST_OK;
        case (it.kind)
            ssg_pkg::KIND_POLY, ssg_pkg::KIND_SEED, ssg_pkg::KIND_BUILD:
            begin
                r.dimension = it.dimension_index;
                if (it.dimension_index == 0
                    || (it.kind == ssg_pkg::KIND_POLY && it.degree == 0))
                    r.status = ssg_pkg::ST_REJECTED;
                else if (it.kind == ssg_pkg::KIND_POLY)
                begin
                    poly_deg[it.dimension_index] = it.degree;
                    poly_coef[it.dimension_index] = it.coefficient_bits;
                end
                else if (it.kind == ssg_pkg::KIND_SEED)
                    dir_tab[it.dimension_index][it.seed_index] =
                        it.seed_value << (WBITS - 1 - it.seed_index);
                else
                    rebuild_directions(it.dimension_index);
                coords_due.push_back(r);
            end
            ssg_pkg::KIND_NEXT:
            begin
                if (!step_point())
                begin
                    r.status = ssg_pkg::ST_EXHAUSTED;
                    coords_due.push_back(r);
                end
                else
                begin
                    n = (dims_reg == 0) ? 1 : ((dims_reg > DIMS) ? DIMS : dims_reg);
                    for (int d = 0; d < n; d++)
                    begin
                        r.coordinate = coord[d];
                        r.dimension  = d[3:0];
                        r.last       = (d == n - 1);
                        coords_due.push_back(r);
                    end
                end
            end
            ssg_pkg::KIND_SKIP:
            begin
                r.status = step_point() ? ssg_pkg::ST_OK : ssg_pkg::ST_EXHAUSTED;
                coords_due.push_back(r);
            end
            ssg_pkg::KIND_RESTART:
            begin
                for (int d = 0; d < DIMS; d++)
                    coord[d] = '0;
                point_cnt = '0;
                coords_due.push_back(r);
            end
            default:
            begin
                r.status = ssg_pkg::ST_REJECTED;
                coords_due.push_back(r);
            end
        endcase
    endfunction

    // fields the command does not use still carry random bits
    function automatic ssg_pkg::item_t make_item(logic [2:0] kind, logic [3:0] dim);
        ssg_pkg::item_t it;
        it.kind             = kind;
        it.dimension_index  = dim;
        it.seed_index       = 5'($urandom_range(0, 31));
        it.seed_value       = $urandom;
        it.degree           = 6'($urandom_range(0, 63));
        it.coefficient_bits = 31'($urandom);
        return it;
    endfunction

    task automatic queue_item(ssg_pkg::item_t it);
        predict_results(it);
        pending_items.push_back(it);
    endtask

    function automatic ssg_pkg::item_t random_item();
        ssg_pkg::item_t it;
        int r;
        r  = $urandom_range(0, 99);
        it = make_item(ssg_pkg::KIND_NEXT, 4'($urandom_range(1, 15)));
        if (r < 45)
            it.kind = ssg_pkg::KIND_NEXT;
        else if (r < 55)
            it.kind = ssg_pkg::KIND_SKIP;
        else if (r < 59)
            it.kind = ssg_pkg::KIND_RESTART;
        else if (r < 69)
        begin
            it.kind = ssg_pkg::KIND_POLY;
            if ($urandom_range(0, 3) != 0)
                it.degree = 6'($urandom_range(1, 8));
        end
        else if (r < 83)
            it.kind = ssg_pkg::KIND_SEED;
        else if (r < 93)
            it.kind = ssg_pkg::KIND_BUILD;
        else if (r < 96)
            it.kind = $urandom_range(0, 1) ? KIND_BAD6 : KIND_BAD7;
        else
        begin
            // setup aimed at the fixed dimension
            it.kind = 3'($urandom_range(0, 2));
            it.dimension_index = 0;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers pending items, holds payload until the transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                items_sent <= items_sent + 1;
            if (!(item_valid && !item_ready))
            begin
                if (tx_gap != 0)
                begin
                    item_valid <= 1'b0;
                    tx_gap     <= tx_gap - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    tx_gap     <= pick_gap();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // one long receiver stall once the queue is deep, so the block backs up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (!hold_done && pending_items.size() > 10)
            begin
                hold_left <= 400;
                hold_done <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compares each result transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        ssg_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen <= results_seen + 1;
                if (coords_due.size() == 0)
                    report("unexpected result", '0, result.coordinate);
                else
                begin
                    want = coords_due.pop_front();
                    if (want.status == ssg_pkg::ST_OK && want.coordinate != 0)
                        points_seen <= points_seen + 1;
                    if (result.coordinate !== want.coordinate)
                        report("coordinate", want.coordinate, result.coordinate);
                    if (result.dimension !== want.dimension)
                        report("dimension", 32'(want.dimension), 32'(result.dimension));
                    if (result.last !== want.last)
                        report("last", 32'(want.last), 32'(result.last));
                    if (result.status !== want.status)
                        report("status", 32'(want.status), 32'(result.status));
                end
            end
            if (rx_gap != 0)
            begin
                rx_gap       <= rx_gap - 1;
                result_ready <= 1'b0;
            end
            else if (hold_left != 0)
                result_ready <= 1'b0;
            else
            begin
                result_ready <= 1'b1;
                if (result_valid && result_ready)
                    rx_gap <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc,
                     coords_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // wait for the block to drain so a register write finds it idle
    task automatic wait_drained();
        while (pending_items.size() != 0 || item_valid || coords_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_dims(logic [4:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        dims_reg = v;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [4:0] dims_plan [6];
        ssg_pkg::item_t it;
        int         s;
        longint     m;

        dims_plan = '{5'd16, 5'd0, 5'd31, 5'd5, 5'd17, 5'd1};
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_wdata = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        points_seen = 0;
        cyc = 0;
        tx_gap = 0;
        rx_gap = 0;
        hold_left = 0;
        hold_done = 1'b0;
        quiet = 1'b0;

        // predictor reset state
        for (int d = 0; d < DIMS; d++)
        begin
            coord[d] = '0;
            poly_deg[d] = '0;
            poly_coef[d] = '0;
            for (int i = 0; i < WBITS; i++)
                dir_tab[d][i] = (d == 0) ? (32'h8000_0000 >> i) : '0;
        end
        point_cnt = '0;
        dims_reg = 5'd1;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // load each dimension but the fixed one before any point is drawn: polynomial,
        // the seeds below its degree, then a build
        for (int d = 1; d < DIMS; d++)
        begin
            it = make_item(ssg_pkg::KIND_POLY, 4'(d));
            it.degree = 6'((d % 5) + 1);
            queue_item(it);
            s = it.degree;
            for (int i = 0; i < s; i++)
            begin
                it = make_item(ssg_pkg::KIND_SEED, 4'(d));
                it.seed_index = 5'(i);
                m = ($urandom % (64'd1 << (i + 1))) | 1;
                it.seed_value = m[31:0];
                queue_item(it);
            end
            queue_item(make_item(ssg_pkg::KIND_BUILD, 4'(d)));
        end

        // directed: extremes and each corner case
        it = make_item(ssg_pkg::KIND_POLY, 4'd15);
        it.degree = 6'd32;
        queue_item(it);                                 // degree of a full word
        it = make_item(ssg_pkg::KIND_SEED, 4'd15);
        it.seed_index = 5'd31;
        it.seed_value = 32'hFFFF_FFFF;
        queue_item(it);                                 // widest seed, unshifted
        it.seed_index = 5'd0;
        it.seed_value = 32'hFFFF_FFFF;
        queue_item(it);                                 // seed truncated by the shift
        queue_item(make_item(ssg_pkg::KIND_BUILD, 4'd15));   // long degree keeps seeds
        it = make_item(ssg_pkg::KIND_POLY, 4'd3);
        it.degree = 6'd0;
        queue_item(it);                                 // zero degree rejected
        it.degree = 6'd63;
        queue_item(it);                                 // degree beyond the word
        queue_item(make_item(ssg_pkg::KIND_BUILD, 4'd3));
        it = make_item(ssg_pkg::KIND_POLY, 4'd2);
        it.degree = 6'd31;
        it.coefficient_bits = 31'h7FFF_FFFF;
        queue_item(it);                                 // all coefficients set
        queue_item(make_item(ssg_pkg::KIND_BUILD, 4'd2));
        queue_item(make_item(ssg_pkg::KIND_BUILD, 4'd2));    // rebuild over itself
        queue_item(make_item(ssg_pkg::KIND_POLY, 4'd0));     // fixed dimension is read only
        queue_item(make_item(ssg_pkg::KIND_SEED, 4'd0));
        queue_item(make_item(ssg_pkg::KIND_BUILD, 4'd0));
        queue_item(make_item(KIND_BAD6, 4'd7));
        queue_item(make_item(KIND_BAD7, 4'd9));
        for (int k = 0; k < 4; k++)
            queue_item(make_item(ssg_pkg::KIND_NEXT, 4'd1));
        queue_item(make_item(ssg_pkg::KIND_SKIP, 4'd1));
        queue_item(make_item(ssg_pkg::KIND_NEXT, 4'd1));
        queue_item(make_item(ssg_pkg::KIND_RESTART, 4'd1));
        queue_item(make_item(ssg_pkg::KIND_NEXT, 4'd1));
        wait_drained();

        // random phases, each under its own dimension count
        for (int p = 0; p < 6; p++)
        begin
            write_dims(dims_plan[p]);
            quiet = (p == 2);
            for (int k = 0; k < 8; k++)
                queue_item(random_item());
            wait_drained();
        end

        $display("run covered %0d item transfers and %0d result transfers", items_sent,
                 results_seen);
        $display("dimension counts 1, 16, 0, 31, 5 and 17; %0d nonzero coordinates checked",
                 points_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
